// ===== hw/rtl/sequence_ring_log_macros.svh =====
// assertion macros used by the sequence ring log checker
`ifndef SEQUENCE_RING_LOG_MACROS_SVH
`define SEQUENCE_RING_LOG_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define SRL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define SRL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/srl_pkg.sv =====
// shared types and constants of the sequence ring log
package srl_pkg;

  localparam int SEQ_W      = 64;
  localparam int PAY_W      = 32;
  localparam int CNT_W      = 7;
  localparam int REQ_W      = 2;
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 176;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TRIM   = 2'd2;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [PAY_W-1:0] pay;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_ROT
  } cell_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

// ===== hw/rtl/srl_cell.sv =====
// one slot of the log chain: holds, takes its newer-side neighbor, or rotates
module srl_cell (
  input  logic               clk,
  input  srl_pkg::cell_mode_t mode,
  input  srl_pkg::entry_t    shift_in,
  input  srl_pkg::entry_t    rot_in,
  output srl_pkg::entry_t    ent
);

  always_ff @(posedge clk) begin
    case (mode)
      srl_pkg::CELL_SHIFT: begin
        ent <= shift_in;
      end
      srl_pkg::CELL_ROT: begin
        ent <= rot_in;
      end
      default: begin
        ent <= ent;
      end
    endcase
  end

endmodule

// ===== hw/rtl/srl_ctrl.sv =====
// sequencer of the log: request capture, scan bookkeeping, bounds and result register
module srl_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [srl_pkg::CNT_W-1:0]       cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [srl_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [srl_pkg::REQ_W-1:0]       s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [srl_pkg::OUT_DATA_W-1:0]  m_tdata,
  output srl_pkg::cell_mode_t             cell_mode,
  input  srl_pkg::entry_t                 head_ent,
  output srl_pkg::entry_t                 new_ent
);

  localparam int CNT_W   = srl_pkg::CNT_W;
  localparam int SEQ_W   = srl_pkg::SEQ_W;
  localparam int PAY_W   = srl_pkg::PAY_W;
  localparam int STEP_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W   = (STEP_W > CNT_W) ? STEP_W : CNT_W;
  localparam int CAP_MAX = (DEPTH > 127) ? 127 : DEPTH;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DEPTH - 1);

  srl_pkg::state_t state, state_next;

  logic [CNT_W-1:0]       cap_reg;
  logic [CNT_W-1:0]       cap_eff;
  logic [CNT_W-1:0]       fill;
  logic [SEQ_W-1:0]       min_trk;
  logic [SEQ_W-1:0]       max_trk;

  logic [srl_pkg::REQ_W-1:0] req;
  logic [SEQ_W-1:0]       key;
  logic [PAY_W-1:0]       pay;
  logic [SEQ_W-1:0]       wm;
  logic                   elig;
  logic [STEP_W-1:0]      step;
  logic                   hit;
  logic [PAY_W-1:0]       hit_pay;
  logic [CNT_W-1:0]       keep_cnt;
  logic [SEQ_W-1:0]       keep_seq;

  logic                   out_free;
  logic                   load_out;
  logic                   accept;
  logic                   in_range;

  logic                   found_n;
  logic [PAY_W-1:0]       fpay_n;
  logic                   evict_n;
  logic [CNT_W-1:0]       trimmed_n;
  logic [CNT_W-1:0]       fill_n;
  logic [SEQ_W-1:0]       min_n;
  logic [SEQ_W-1:0]       max_n;

  logic [SEQ_W-1:0]       in_seq;
  logic [PAY_W-1:0]       in_pay;
  logic [SEQ_W-1:0]       in_wm;

  assign in_seq = s_tdata[63:0];
  assign in_pay = s_tdata[95:64];
  assign in_wm  = s_tdata[159:96];

  // register value 0 acts as one slot, anything past the chain as the whole chain
  always_comb begin
    if (cap_reg == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_reg > CNT_W'(CAP_MAX)) begin
      cap_eff = CNT_W'(CAP_MAX);
    end else begin
      cap_eff = cap_reg;
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign in_range = CMP_W'(step) < CMP_W'(fill);
  assign new_ent  = '{seq: key, pay: pay};

  always_comb begin
    state_next = state;
    case (state)
      srl_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == srl_pkg::REQ_LOOKUP || s_tuser == srl_pkg::REQ_TRIM) begin
            state_next = srl_pkg::ST_SCAN;
          end else begin
            state_next = srl_pkg::ST_FINISH;
          end
        end
      end
      srl_pkg::ST_SCAN: begin
        if (step == STEP_LAST) begin
          state_next = srl_pkg::ST_FINISH;
        end
      end
      srl_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = srl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = srl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    load_out  = 1'b0;
    cell_mode = srl_pkg::CELL_HOLD;
    case (state)
      srl_pkg::ST_IDLE: begin
        s_tready = !rst;
      end
      srl_pkg::ST_SCAN: begin
        cell_mode = srl_pkg::CELL_ROT;
      end
      srl_pkg::ST_FINISH: begin
        load_out = out_free;
        if (out_free && req == srl_pkg::REQ_APPEND) begin
          cell_mode = srl_pkg::CELL_SHIFT;
        end
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // result and new bounds, settled in the finishing cycle
  always_comb begin
    found_n   = 1'b0;
    fpay_n    = '0;
    evict_n   = 1'b0;
    trimmed_n = '0;
    fill_n    = fill;
    min_n     = min_trk;
    max_n     = max_trk;
    case (req)
      srl_pkg::REQ_APPEND: begin
        evict_n = (fill >= cap_eff);
        fill_n  = evict_n ? fill : fill + CNT_W'(1);
        if (fill_n == CNT_W'(1)) begin
          min_n = key;
          max_n = key;
        end else begin
          min_n = (key < min_trk) ? key : min_trk;
          max_n = (key > max_trk) ? key : max_trk;
        end
      end
      srl_pkg::REQ_LOOKUP: begin
        found_n = hit;
        fpay_n  = hit_pay;
      end
      srl_pkg::REQ_TRIM: begin
        fill_n    = keep_cnt;
        trimmed_n = fill - keep_cnt;
        min_n     = (keep_cnt != '0) ? keep_seq : '0;
        max_n     = (keep_cnt != '0) ? max_trk : '0;
      end
      default: begin
        fill_n = fill;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= srl_pkg::ST_IDLE;
      cap_reg  <= srl_pkg::CAP_RESET;
      fill     <= '0;
      min_trk  <= '0;
      max_trk  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        cap_reg <= cfg_wdata;
        fill    <= '0;
        min_trk <= '0;
        max_trk <= '0;
      end else if (load_out) begin
        fill    <= fill_n;
        min_trk <= min_n;
        max_trk <= max_n;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // scan walks the chain newest first, one slot per cycle at cell 0
  always_ff @(posedge clk) begin
    if (accept) begin
      req      <= s_tuser;
      key      <= in_seq;
      pay      <= in_pay;
      wm       <= in_wm;
      elig     <= (fill != '0) && (in_seq >= min_trk) && (in_seq <= max_trk);
      step     <= '0;
      hit      <= 1'b0;
      hit_pay  <= '0;
      keep_cnt <= '0;
      keep_seq <= '0;
    end else if (state == srl_pkg::ST_SCAN) begin
      step <= step + STEP_W'(1);
      if (req == srl_pkg::REQ_LOOKUP) begin
        if (elig && in_range && !hit && head_ent.seq == key) begin
          hit     <= 1'b1;
          hit_pay <= head_ent.pay;
        end
      end else begin
        // last slot at or above the watermark is the oldest one kept
        if (in_range && head_ent.seq >= wm) begin
          keep_cnt <= CNT_W'(step) + CNT_W'(1);
          keep_seq <= head_ent.seq;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {max_n, min_n, fill_n, trimmed_n, evict_n, fpay_n, found_n};
    end
  end

endmodule

// ===== hw/rtl/sequence_ring_log.sv =====
// top level of the sequence ring log: sequencer plus the chain of entry cells
//
// requests come in on s_tvalid/s_tready/s_tdata/s_tuser, one beat per request;
// s_tuser selects append, lookup or trim. every request gives exactly one result
// beat on m_tvalid/m_tready/m_tdata.
// entries live in a chain of DEPTH cells, newest in cell 0. append shifts the
// chain by one slot; lookup and trim rotate it once all the way round, so
// cell 0 shows every slot newest first and the order is back when the pass ends.
// the result beat is registered from the finishing state, which append and the
// unused request code enter straight from idle, and lookup and trim enter after
// the rotation pass.
// one request is worked at a time; the next one is taken as soon as the
// previous result sits in the output register.
// a stalled receiver holds the finished result there; a further request is
// accepted and scanned, then waits until the output register frees up.
// cfg_we writes the slot count in use and empties the log; write it only
// while idle. reset empties the log and sets the slot count to 64.
module sequence_ring_log #(
  parameter int DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [srl_pkg::CNT_W-1:0]       cfg_wdata,   // capacity_in_use
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // seq_number [63:0], payload_handle [95:64], watermark [159:96]
  input  logic [srl_pkg::IN_DATA_W-1:0]   s_tdata,
  // req_type [1:0]
  input  logic [srl_pkg::REQ_W-1:0]       s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // found [0], found_payload [32:1], evicted [33], trimmed_count [40:34],
  // entry_count [47:41], min_seq [111:48], max_seq [175:112]
  output logic [srl_pkg::OUT_DATA_W-1:0]  m_tdata
);

  srl_pkg::cell_mode_t cell_mode;
  srl_pkg::entry_t     new_ent;
  srl_pkg::entry_t     ents [DEPTH];

  srl_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cell_mode (cell_mode),
    .head_ent  (ents[0]),
    .new_ent   (new_ent)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    srl_pkg::entry_t shift_in;
    if (i == 0) begin : g_first
      assign shift_in = new_ent;
    end else begin : g_rest
      assign shift_in = ents[i-1];
    end
    srl_cell u_cell (
      .clk      (clk),
      .mode     (cell_mode),
      .shift_in (shift_in),
      .rot_in   (ents[(i + 1) % DEPTH]),
      .ent      (ents[i])
    );
  end

endmodule

// ===== hw/rtl/srl_checker.sv =====
// port-level checks of the sequence ring log, bound to the top level
`include "sequence_ring_log_macros.svh"

module srl_checker #(
  parameter int DEPTH = 64
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [srl_pkg::OUT_DATA_W-1:0]  m_tdata
);

  `SRL_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
  `SRL_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tdata[0], m_tdata[32:1] == '0, "miss carries a payload")
  `SRL_ASSERT_IMP(a_evict_only, m_tvalid && m_tdata[33], !m_tdata[0] && m_tdata[40:34] == '0, "eviction mixed with other results")
  `SRL_ASSERT_IMP(a_empty_bounds, m_tvalid && m_tdata[47:41] == '0, m_tdata[111:48] == '0 && m_tdata[175:112] == '0, "empty log with nonzero bounds")
  `SRL_ASSERT_IMP(a_count_max, m_tvalid, 32'(m_tdata[47:41]) <= DEPTH, "entry count beyond chain length")

endmodule

bind sequence_ring_log srl_checker #(
  .DEPTH (DEPTH)
) u_srl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
